// File: hdl/multi_reader_block_ring_control_assert.svh
// Assertion macros for the ring control block.
// Define NO_ASSERTIONS to compile them away.
`ifndef MULTI_READER_BLOCK_RING_CONTROL_ASSERT_SVH
`define MULTI_READER_BLOCK_RING_CONTROL_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/mrbrc_pkg.sv
// Package for the ring control block: action and status codes, controller types.
// No dependencies.
package mrbrc_pkg;
	localparam int unsigned FRAME_W = 31;
	localparam int unsigned PER_W = 16;
	localparam int unsigned ID_W = 3;
	localparam int unsigned CNT_W = 7;
	localparam int unsigned MAX_SLOTS = 64;
	localparam int unsigned MAX_READERS = 8;

	typedef enum logic [2:0] {
		ACT_WRITE = 3'd0,
		ACT_CLAIM = 3'd1,
		ACT_ADVANCE = 3'd2,
		ACT_ADD = 3'd3,
		ACT_DELETE = 3'd4,
		ACT_CLEAR = 3'd5,
		ACT_NOP6 = 3'd6,
		ACT_NOP7 = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_EMPTY = 3'd1,
		ST_FULL = 3'd2,
		ST_CLAIMED = 3'd3,
		ST_NOT_DUE = 3'd4,
		ST_WAITING = 3'd5,
		ST_NO_ROOM = 3'd6,
		ST_INACTIVE = 3'd7
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_EXEC = 5'b00100,
		S_MOD = 5'b01000,
		S_OUT = 5'b10000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic mod_start;
		logic mod_step;
		logic finish;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_mod;
		logic mod_done;
	} stat_t;
endpackage

// File: hdl/mrbrc_if.sv
// Valid/ready channel interfaces for the ring control block.
// Uses mrbrc_pkg for field widths.
interface mrbrc_in_if;
	logic valid;
	logic ready;
	logic [2:0] action;
	logic [2:0] reader_id;
	logic [mrbrc_pkg::FRAME_W-1:0] frame_index;
	logic gate_by_frame;
	modport source (output valid, action, reader_id, frame_index, gate_by_frame, input ready);
	modport sink (input valid, action, reader_id, frame_index, gate_by_frame, output ready);
endinterface

interface mrbrc_out_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [5:0] slot;
	logic [2:0] new_reader;
	logic sync_pulse;
	logic [mrbrc_pkg::FRAME_W-1:0] sync_frame;
	logic enough_buffered;
	modport source (output valid, status, slot, new_reader, sync_pulse, sync_frame,
		enough_buffered, input ready);
	modport sink (input valid, status, slot, new_reader, sync_pulse, sync_frame,
		enough_buffered, output ready);
endinterface

// File: hdl/multi_reader_block_ring_control.sv
// Top level of the ring control block: controller, datapath, output register.
// Uses mrbrc_pkg, the channel interfaces and the assertion header.
//
// Input channel carries one action (write, claim, advance, add/delete reader,
// clear); the output channel returns exactly one result per action.
// An item goes through accept, head read, execute and output load before the
// next accept. A pop with sync enabled adds a 31-step bit-serial modulo and
// the sync compare before the output load.
// The result turns valid with the load of the output register.
// One item is in work at a time; a stalled receiver keeps one result in the
// output register while the next item runs and then waits in its output
// state, holding the input off until the waiting result is taken.
// Reset: ring empty, only reader 0 active, registers at 64/1/0/30.
// Configuration is a plain write port; index 0 slot_count, 1
// keyframe_period, 2 sync_enable, 3 ready_level.
`include "multi_reader_block_ring_control_assert.svh"
module multi_reader_block_ring_control (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	mrbrc_in_if.sink in_ch,
	mrbrc_out_if.source out_ch
);
	mrbrc_pkg::cmd_t cmd;
	mrbrc_pkg::stat_t stat;
	logic [2:0] st;
	logic [5:0] sl;
	logic [2:0] nr;
	logic sp, eb;
	logic [mrbrc_pkg::FRAME_W-1:0] sf;
	logic [2:0] status_q, new_reader_q;
	logic [5:0] slot_q;
	logic sync_pulse_q, enough_q;
	logic [mrbrc_pkg::FRAME_W-1:0] sync_frame_q;

	mrbrc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .cmd(cmd)
	);

	mrbrc_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.action(in_ch.action), .reader_id(in_ch.reader_id),
		.frame_index(in_ch.frame_index), .gate_by_frame(in_ch.gate_by_frame),
		.cmd(cmd), .stat(stat),
		.status(st), .slot(sl), .new_reader(nr), .sync_pulse(sp),
		.sync_frame(sf), .enough_buffered(eb)
	);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= st;
			slot_q <= sl;
			new_reader_q <= nr;
			sync_pulse_q <= sp;
			sync_frame_q <= sf;
			enough_q <= eb;
		end
	end

	assign out_ch.status = status_q;
	assign out_ch.slot = slot_q;
	assign out_ch.new_reader = new_reader_q;
	assign out_ch.sync_pulse = sync_pulse_q;
	assign out_ch.sync_frame = sync_frame_q;
	assign out_ch.enough_buffered = enough_q;

	`RC_ASSERT_NEXT(a_no_accept_busy, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
	`RC_ASSERT_IMP(a_start_in_exec, clk, arst_n, cmd.mod_start, cmd.exec)
	`RC_ASSERT_IMP(a_finish_not_load, clk, arst_n, cmd.finish, !cmd.load)
	`RC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule

// File: hdl/mrbrc_ctrl.sv
// Controller state machine of the ring control block.
// Uses mrbrc_pkg command and status types.
module mrbrc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input mrbrc_pkg::stat_t stat,
	output mrbrc_pkg::cmd_t cmd
);
	mrbrc_pkg::state_t state_q;
	logic out_valid_q;

	assign in_ready = (state_q == mrbrc_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.exec = (state_q == mrbrc_pkg::S_EXEC);
		cmd.mod_start = (state_q == mrbrc_pkg::S_EXEC) && stat.need_mod;
		cmd.mod_step = (state_q == mrbrc_pkg::S_MOD) && !stat.mod_done;
		cmd.finish = (state_q == mrbrc_pkg::S_MOD) && stat.mod_done;
		// load the output register only once the previous result has gone
		cmd.emit = (state_q == mrbrc_pkg::S_OUT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrbrc_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				mrbrc_pkg::S_IDLE: begin
					if (in_valid) state_q <= mrbrc_pkg::S_READ;
				end
				mrbrc_pkg::S_READ: state_q <= mrbrc_pkg::S_EXEC;
				mrbrc_pkg::S_EXEC: begin
					if (stat.need_mod) state_q <= mrbrc_pkg::S_MOD;
					else state_q <= mrbrc_pkg::S_OUT;
				end
				mrbrc_pkg::S_MOD: begin
					if (stat.mod_done) state_q <= mrbrc_pkg::S_OUT;
				end
				mrbrc_pkg::S_OUT: begin
					if (cmd.emit) begin
						out_valid_q <= 1'b1;
						state_q <= mrbrc_pkg::S_IDLE;
					end
				end
				default: state_q <= mrbrc_pkg::S_IDLE;
			endcase
		end
	end
endmodule

// File: hdl/mrbrc_dp.sv
// Datapath of the ring control block: pointers, readers, slot memory, serial modulo.
// Uses mrbrc_pkg codes and the controller command struct.
module mrbrc_dp (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic [2:0] action,
	input logic [2:0] reader_id,
	input logic [mrbrc_pkg::FRAME_W-1:0] frame_index,
	input logic gate_by_frame,
	input mrbrc_pkg::cmd_t cmd,
	output mrbrc_pkg::stat_t stat,
	output logic [2:0] status,
	output logic [5:0] slot,
	output logic [2:0] new_reader,
	output logic sync_pulse,
	output logic [mrbrc_pkg::FRAME_W-1:0] sync_frame,
	output logic enough_buffered
);
	localparam int unsigned MAX_SLOTS = mrbrc_pkg::MAX_SLOTS;
	localparam int unsigned MAX_READERS = mrbrc_pkg::MAX_READERS;
	localparam int unsigned PW = $clog2(MAX_SLOTS);
	localparam int unsigned SW = PW + 1;
	localparam int unsigned RN = (MAX_READERS < 8) ? MAX_READERS : 8;
	localparam int unsigned FW = mrbrc_pkg::FRAME_W;

	logic [6:0] slot_count_q, ready_level_q;
	logic [15:0] period_q;
	logic sync_en_q;
	logic [PW-1:0] rp_q, wp_q;
	logic full_q, empty_q;
	logic [MAX_READERS-1:0] active_q, claimed_q;
	logic [15:0] last_phase_q;
	logic [FW-1:0] mem [MAX_SLOTS];
	logic [FW-1:0] head_q;
	logic [2:0] act_q, rid_q;
	logic [FW-1:0] frame_q;
	logic gate_q;
	logic [2:0] status_q, newr_q;
	logic [5:0] slot_q;
	logic pulse_q;
	logic [FW-1:0] sframe_q;
	logic enough_q;
	logic [16:0] rem_q;
	logic [FW-1:0] quo_q;
	logic [4:0] bits_q;

	logic [SW-1:0] ring_n;
	always_comb begin
		if (slot_count_q < 7'd3) ring_n = SW'(3);
		else if (slot_count_q > 7'(MAX_SLOTS)) ring_n = SW'(MAX_SLOTS);
		else ring_n = SW'(slot_count_q);
	end

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p, input logic [SW-1:0] n);
		logic [SW-1:0] p1;
		p1 = {1'b0, p} + SW'(1);
		return (p1 >= n) ? '0 : p1[PW-1:0];
	endfunction

	function automatic logic [SW-1:0] fill(input logic e, input logic [PW-1:0] r,
		input logic [PW-1:0] w, input logic [SW-1:0] n);
		logic [SW-1:0] d;
		d = {1'b0, r} - {1'b0, w};
		if (e) return '0;
		if (w > r) return {1'b0, w} - {1'b0, r};
		if (d <= n) return n - d;
		return '0;
	endfunction

	logic valid_id, rid_active, rid_claimed;
	logic all_claimed, has_free;
	logic [2:0] free_id;
	always_comb begin
		valid_id = {2'b0, rid_q} < 5'(RN);
		rid_active = valid_id && active_q[rid_q];
		rid_claimed = claimed_q[rid_q];
		all_claimed = ((active_q & ~claimed_q) == '0);
		has_free = 1'b0;
		free_id = '0;
		for (int i = RN - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				has_free = 1'b1;
				free_id = 3'(i);
			end
		end
	end

	logic [PW-1:0] wp_n, rp_n;
	assign wp_n = nxt(wp_q, ring_n);
	assign rp_n = nxt(rp_q, ring_n);

	// post-step state, for the buffered level
	logic [PW-1:0] rp_a, wp_a;
	logic empty_a;
	always_comb begin
		rp_a = rp_q;
		wp_a = wp_q;
		empty_a = empty_q;
		case (act_q)
			mrbrc_pkg::ACT_WRITE: if (!full_q) begin
				wp_a = wp_n;
				empty_a = 1'b0;
			end
			mrbrc_pkg::ACT_ADVANCE: if (!empty_q && all_claimed) begin
				rp_a = rp_n;
				empty_a = (rp_n == wp_q);
			end
			mrbrc_pkg::ACT_CLEAR: begin
				rp_a = '0;
				wp_a = '0;
				empty_a = 1'b1;
			end
			default: ;
		endcase
	end

	// only a pop with sync enabled runs the modulo
	assign stat.need_mod = sync_en_q && (act_q == mrbrc_pkg::ACT_ADVANCE) && !empty_q
		&& all_claimed;
	assign stat.mod_done = (bits_q == 5'd0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			rid_q <= reader_id;
			frame_q <= frame_index;
			gate_q <= gate_by_frame;
		end
		head_q <= mem[rp_q];
		if (cmd.exec && act_q == mrbrc_pkg::ACT_WRITE && !full_q)
			mem[wp_q] <= frame_q;
	end

	logic [16:0] rem_sh;
	logic [16:0] per17;
	assign per17 = {1'b0, (period_q == 16'd0) ? 16'd1 : period_q};
	assign rem_sh = {rem_q[15:0], quo_q[FW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= 7'd64;
			period_q <= 16'd1;
			sync_en_q <= 1'b0;
			ready_level_q <= 7'd30;
			rp_q <= '0;
			wp_q <= '0;
			full_q <= 1'b0;
			empty_q <= 1'b1;
			active_q <= MAX_READERS'(1);
			claimed_q <= '0;
			last_phase_q <= '0;
			bits_q <= '0;
			status_q <= '0;
			slot_q <= '0;
			newr_q <= '0;
			pulse_q <= 1'b0;
			sframe_q <= '0;
			enough_q <= 1'b0;
			rem_q <= '0;
			quo_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					2'd0: slot_count_q <= cfg_data[6:0];
					2'd1: period_q <= cfg_data;
					2'd2: sync_en_q <= cfg_data[0];
					default: ready_level_q <= cfg_data[6:0];
				endcase
			end
			if (cmd.exec) begin
				status_q <= mrbrc_pkg::ST_OK;
				slot_q <= '0;
				newr_q <= '0;
				pulse_q <= 1'b0;
				sframe_q <= '0;
				enough_q <= fill(empty_a, rp_a, wp_a, ring_n) >= SW'(ready_level_q);
				case (act_q)
					mrbrc_pkg::ACT_WRITE: begin
						if (full_q) status_q <= mrbrc_pkg::ST_FULL;
						else begin
							slot_q <= 6'(wp_q);
							wp_q <= wp_n;
							if (nxt(wp_n, ring_n) == rp_q) full_q <= 1'b1;
							empty_q <= 1'b0;
						end
					end
					mrbrc_pkg::ACT_CLAIM: begin
						if (!rid_active) status_q <= mrbrc_pkg::ST_INACTIVE;
						else if (empty_q) status_q <= mrbrc_pkg::ST_EMPTY;
						else if (rid_claimed) status_q <= mrbrc_pkg::ST_CLAIMED;
						else if (gate_q && frame_q < head_q) status_q <= mrbrc_pkg::ST_NOT_DUE;
						else begin
							claimed_q[rid_q] <= 1'b1;
							slot_q <= 6'(rp_q);
						end
					end
					mrbrc_pkg::ACT_ADVANCE: begin
						if (empty_q) status_q <= mrbrc_pkg::ST_EMPTY;
						else if (!all_claimed) status_q <= mrbrc_pkg::ST_WAITING;
						else begin
							sframe_q <= head_q;
							rp_q <= rp_n;
							full_q <= 1'b0;
							if (rp_n == wp_q) empty_q <= 1'b1;
							claimed_q <= '0;
							slot_q <= 6'(rp_n);
							if (cmd.mod_start) begin
								quo_q <= head_q;
								rem_q <= '0;
								bits_q <= 5'(FW);
							end
						end
					end
					mrbrc_pkg::ACT_ADD: begin
						if (has_free) begin
							active_q[free_id] <= 1'b1;
							claimed_q[free_id] <= 1'b0;
							newr_q <= free_id;
						end else status_q <= mrbrc_pkg::ST_NO_ROOM;
					end
					mrbrc_pkg::ACT_DELETE: begin
						if (!rid_active) status_q <= mrbrc_pkg::ST_INACTIVE;
						else begin
							active_q[rid_q] <= 1'b0;
							claimed_q[rid_q] <= 1'b0;
						end
					end
					mrbrc_pkg::ACT_CLEAR: begin
						rp_q <= '0;
						wp_q <= '0;
						full_q <= 1'b0;
						empty_q <= 1'b1;
						active_q <= MAX_READERS'(1);
						claimed_q <= '0;
					end
					default: ;
				endcase
			end else if (cmd.mod_step) begin
				// restoring division, one quotient bit a cycle
				rem_q <= (rem_sh >= per17) ? rem_sh - per17 : rem_sh;
				quo_q <= {quo_q[FW-2:0], 1'b0};
				bits_q <= bits_q - 5'd1;
			end else if (cmd.finish) begin
				pulse_q <= rem_q[15:0] < last_phase_q;
				last_phase_q <= rem_q[15:0];
			end
		end
	end

	assign status = status_q;
	assign slot = slot_q;
	assign new_reader = newr_q;
	assign sync_pulse = pulse_q;
	assign sync_frame = sframe_q;
	assign enough_buffered = enough_q;
endmodule

// File: sim/multi_reader_block_ring_control_test.sv
// Testbench for the ring control block: directed table, then random actions.
// Predicts every result in a local model and checks fields in order.
// Depends on mrbrc_pkg, the channel interfaces and the block RTL.
module multi_reader_block_ring_control_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] slot;
		logic [2:0] new_reader;
		logic sync_pulse;
		logic [30:0] sync_frame;
		logic enough_buffered;
	} ring_result_t;

	typedef struct {
		mrbrc_pkg::action_t act;
		logic [2:0] rid;
		logic [30:0] frame;
		logic gate;
		logic typed;
		mrbrc_pkg::status_t want_status;
	} table_row_t;

	localparam int MAX_CYCLES = 1500000;
	localparam int LATENCY = 60;
	localparam int REG_SLOTS = 0, REG_PERIOD = 1, REG_SYNC = 2, REG_LEVEL = 3;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	mrbrc_in_if in_ch();
	mrbrc_out_if out_ch();

	multi_reader_block_ring_control i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	// predictor state
	int unsigned ring_slots, kf_period, sync_on, level_mark;
	int unsigned rd_ptr, wr_ptr;
	bit ring_full, ring_empty;
	logic [30:0] frames[64];
	bit active[8], claimed[8];
	int unsigned claims, last_phase;

	ring_result_t expected_results[$];
	logic [2:0] typed_status[$];
	bit status_typed[$];
	int errors = 0;
	int cycles = 0;
	int send_idle = 35, recv_idle = 63;
	bit hold_off = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("multi_reader_block_ring_control verification failed");
			$finish;
		end
	end

	function automatic int unsigned ring_len();
		return ring_slots < 3 ? 3 : (ring_slots > 64 ? 64 : ring_slots);
	endfunction

	function automatic int unsigned step_ptr(int unsigned p);
		return (p + 1 >= ring_len()) ? 0 : p + 1;
	endfunction

	function automatic int unsigned fill_now();
		if (ring_empty) return 0;
		if (wr_ptr > rd_ptr) return wr_ptr - rd_ptr;
		if (rd_ptr - wr_ptr <= ring_len()) return ring_len() - (rd_ptr - wr_ptr);
		return 0;
	endfunction

	function automatic logic [30:0] head_frame();
		return rd_ptr < 64 ? frames[rd_ptr] : '0;
	endfunction

	function automatic void clear_readers();
		rd_ptr = 0; wr_ptr = 0; ring_full = 0; ring_empty = 1; claims = 0;
		foreach (active[i]) begin
			active[i] = (i == 0); claimed[i] = 0;
		end
	endfunction

	function automatic ring_result_t ring_step(mrbrc_pkg::action_t act, logic [2:0] rid,
		logic [30:0] frame, logic gate);
		ring_result_t r;
		bit all_in;
		int unsigned phase, per;
		r = '0;
		case (act)
			mrbrc_pkg::ACT_WRITE: begin
				if (ring_full) r.status = mrbrc_pkg::ST_FULL;
				else begin
					frames[wr_ptr] = frame;
					r.slot = 6'(wr_ptr);
					wr_ptr = step_ptr(wr_ptr);
					if (step_ptr(wr_ptr) == rd_ptr) ring_full = 1;
					ring_empty = 0;
				end
			end
			mrbrc_pkg::ACT_CLAIM: begin
				if (!active[rid]) r.status = mrbrc_pkg::ST_INACTIVE;
				else if (ring_empty) r.status = mrbrc_pkg::ST_EMPTY;
				else if (claimed[rid]) r.status = mrbrc_pkg::ST_CLAIMED;
				else if (gate && frame < head_frame()) r.status = mrbrc_pkg::ST_NOT_DUE;
				else begin
					claimed[rid] = 1; claims = (claims + 1) & 15; r.slot = 6'(rd_ptr);
				end
			end
			mrbrc_pkg::ACT_ADVANCE: begin
				all_in = 1;
				foreach (active[i]) if (active[i] && !claimed[i]) all_in = 0;
				if (ring_empty) r.status = mrbrc_pkg::ST_EMPTY;
				else if (!all_in) r.status = mrbrc_pkg::ST_WAITING;
				else begin
					r.sync_frame = head_frame();
					rd_ptr = step_ptr(rd_ptr);
					ring_full = 0;
					if (rd_ptr == wr_ptr) ring_empty = 1;
					foreach (claimed[i]) claimed[i] = 0;
					claims = 0;
					if (sync_on) begin
						per = kf_period ? kf_period : 1;
						phase = r.sync_frame % per;
						if (phase < last_phase) r.sync_pulse = 1;
						last_phase = phase & 16'hffff;
					end
					r.slot = 6'(rd_ptr);
				end
			end
			mrbrc_pkg::ACT_ADD: begin
				r.status = mrbrc_pkg::ST_NO_ROOM;
				for (int i = 0; i < 8; i++) if (!active[i]) begin
					active[i] = 1; claimed[i] = 0; r.new_reader = 3'(i);
					r.status = mrbrc_pkg::ST_OK;
					break;
				end
			end
			mrbrc_pkg::ACT_DELETE: begin
				if (!active[rid]) r.status = mrbrc_pkg::ST_INACTIVE;
				else begin
					if (claimed[rid] && claims > 0) claims--;
					claimed[rid] = 0; active[rid] = 0;
				end
			end
			mrbrc_pkg::ACT_CLEAR: clear_readers();
			default: ;
		endcase
		r.enough_buffered = fill_now() >= level_mark;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// receiver and checker
	initial begin
		ring_result_t e;
		out_ch.ready <= 0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0)
					report_mismatch("unexpected result", out_ch.status, -1);
				else begin
					e = expected_results.pop_front();
					if (status_typed.pop_front() && out_ch.status !== typed_status[0])
						report_mismatch("table status", out_ch.status, typed_status[0]);
					void'(typed_status.pop_front());
					if (out_ch.status !== e.status) report_mismatch("status", out_ch.status, e.status);
					if (out_ch.slot !== e.slot) report_mismatch("slot", out_ch.slot, e.slot);
					if (out_ch.new_reader !== e.new_reader)
						report_mismatch("new_reader", out_ch.new_reader, e.new_reader);
					if (out_ch.sync_pulse !== e.sync_pulse)
						report_mismatch("sync_pulse", out_ch.sync_pulse, e.sync_pulse);
					if (out_ch.sync_frame !== e.sync_frame)
						report_mismatch("sync_frame", out_ch.sync_frame, e.sync_frame);
					if (out_ch.enough_buffered !== e.enough_buffered)
						report_mismatch("enough_buffered", out_ch.enough_buffered,
							e.enough_buffered);
				end
			end
			out_ch.ready <= hold_off ? 1'b0 : ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic write_reg(int idx, int unsigned value);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= 2'(idx); cfg_data <= 16'(value);
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_SLOTS: ring_slots = value & 7'h7f;
			REG_PERIOD: kf_period = value & 16'hffff;
			REG_SYNC: sync_on = value & 1;
			default: level_mark = value & 7'h7f;
		endcase
	endtask

	task automatic drain();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// transfer one action; valid stays high so the next item can follow at once,
	// the caller drops it after the last item
	task automatic send_action(mrbrc_pkg::action_t act, logic [2:0] rid, logic [30:0] frame,
		logic gate, bit typed, mrbrc_pkg::status_t want);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.action <= act; in_ch.reader_id <= rid;
		in_ch.frame_index <= frame; in_ch.gate_by_frame <= gate;
		expected_results = {expected_results, ring_step(act, rid, frame, gate)};
		status_typed = {status_typed, typed};
		typed_status = {typed_status, want};
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// pick a reader id, preferring active ones
	function automatic logic [2:0] pick_reader();
		logic [2:0] r;
		for (int k = 0; k < 8; k++) begin
			r = 3'($urandom_range(7));
			if (active[r]) return r;
		end
		return 3'($urandom_range(7));
	endfunction

	task automatic random_actions(int count);
		int pick;
		mrbrc_pkg::action_t act;
		logic [30:0] frame;
		logic [2:0] rid;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			act = pick < 30 ? mrbrc_pkg::ACT_WRITE : pick < 62 ? mrbrc_pkg::ACT_CLAIM :
				pick < 84 ? mrbrc_pkg::ACT_ADVANCE : pick < 90 ? mrbrc_pkg::ACT_ADD :
				pick < 95 ? mrbrc_pkg::ACT_DELETE : pick < 97 ? mrbrc_pkg::ACT_CLEAR :
				($urandom_range(1) ? mrbrc_pkg::ACT_NOP6 : mrbrc_pkg::ACT_NOP7);
			rid = pick_reader();
			frame = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(400));
			// keep gated claims near the head frame so both outcomes appear
			if (act == mrbrc_pkg::ACT_CLAIM && !ring_empty && $urandom_range(1))
				frame = head_frame() + 31'($urandom_range(4)) - 31'd2;
			send_action(act, rid, frame, 1'($urandom_range(1)), 0, mrbrc_pkg::ST_OK);
		end
		in_ch.valid <= 0;
	endtask

	table_row_t directed[] = '{
		'{mrbrc_pkg::ACT_ADVANCE, 0, 0, 0, 1, mrbrc_pkg::ST_EMPTY},
		'{mrbrc_pkg::ACT_CLAIM, 0, 0, 0, 1, mrbrc_pkg::ST_EMPTY},
		'{mrbrc_pkg::ACT_CLAIM, 5, 0, 0, 1, mrbrc_pkg::ST_INACTIVE},
		'{mrbrc_pkg::ACT_DELETE, 7, 0, 0, 1, mrbrc_pkg::ST_INACTIVE},
		'{mrbrc_pkg::ACT_WRITE, 0, 31'h7fffffff, 1, 1, mrbrc_pkg::ST_OK},
		'{mrbrc_pkg::ACT_WRITE, 7, 0, 0, 1, mrbrc_pkg::ST_OK},
		'{mrbrc_pkg::ACT_WRITE, 0, 31'h2aaaaaaa, 0, 1, mrbrc_pkg::ST_FULL},
		'{mrbrc_pkg::ACT_WRITE, 0, 31'h55555555, 0, 1, mrbrc_pkg::ST_FULL},
		'{mrbrc_pkg::ACT_CLAIM, 0, 31'h7ffffffe, 1, 1, mrbrc_pkg::ST_NOT_DUE},
		'{mrbrc_pkg::ACT_ADVANCE, 0, 0, 0, 1, mrbrc_pkg::ST_WAITING},
		'{mrbrc_pkg::ACT_CLAIM, 0, 31'h7fffffff, 1, 1, mrbrc_pkg::ST_OK},
		'{mrbrc_pkg::ACT_CLAIM, 0, 0, 0, 1, mrbrc_pkg::ST_CLAIMED},
		'{mrbrc_pkg::ACT_ADD, 0, 0, 0, 0, mrbrc_pkg::ST_OK},
		'{mrbrc_pkg::ACT_ADVANCE, 0, 0, 0, 1, mrbrc_pkg::ST_WAITING},
		'{mrbrc_pkg::ACT_DELETE, 1, 0, 0, 1, mrbrc_pkg::ST_OK},
		'{mrbrc_pkg::ACT_ADVANCE, 0, 0, 0, 0, mrbrc_pkg::ST_OK},
		'{mrbrc_pkg::ACT_ADD, 0, 0, 0, 0, mrbrc_pkg::ST_OK},
		'{mrbrc_pkg::ACT_ADD, 0, 0, 0, 0, mrbrc_pkg::ST_OK},
		'{mrbrc_pkg::ACT_ADD, 0, 0, 0, 0, mrbrc_pkg::ST_OK},
		'{mrbrc_pkg::ACT_ADD, 0, 0, 0, 0, mrbrc_pkg::ST_OK},
		'{mrbrc_pkg::ACT_ADD, 0, 0, 0, 0, mrbrc_pkg::ST_OK},
		'{mrbrc_pkg::ACT_ADD, 0, 0, 0, 0, mrbrc_pkg::ST_OK},
		'{mrbrc_pkg::ACT_ADD, 0, 0, 0, 0, mrbrc_pkg::ST_OK},
		'{mrbrc_pkg::ACT_ADD, 0, 0, 0, 1, mrbrc_pkg::ST_NO_ROOM},
		'{mrbrc_pkg::ACT_NOP6, 3, 7, 1, 1, mrbrc_pkg::ST_OK},
		'{mrbrc_pkg::ACT_CLEAR, 0, 0, 0, 0, mrbrc_pkg::ST_OK},
		'{mrbrc_pkg::ACT_DELETE, 0, 0, 0, 0, mrbrc_pkg::ST_OK},
		'{mrbrc_pkg::ACT_NOP7, 0, 0, 0, 1, mrbrc_pkg::ST_OK}
	};

	initial begin
		in_ch.valid <= 0; in_ch.action <= mrbrc_pkg::ACT_WRITE; in_ch.reader_id <= '0;
		in_ch.frame_index <= '0; in_ch.gate_by_frame <= 0;
		ring_slots = 64; kf_period = 1; sync_on = 0; level_mark = 30; last_phase = 0;
		foreach (frames[i]) frames[i] = '0;
		clear_readers();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		write_reg(REG_SLOTS, 3);
		write_reg(REG_LEVEL, 2);
		foreach (directed[i])
			send_action(directed[i].act, directed[i].rid, directed[i].frame,
				directed[i].gate, directed[i].typed, directed[i].want_status);
		in_ch.valid <= 0;
		drain();
		// clearing the ring keeps old frames; restart with a fresh ring for random work
		send_action(mrbrc_pkg::ACT_CLEAR, 0, 0, 0, 0, mrbrc_pkg::ST_OK);
		in_ch.valid <= 0;
		drain();
		write_reg(REG_SLOTS, 8); write_reg(REG_PERIOD, 10);
		write_reg(REG_SYNC, 1); write_reg(REG_LEVEL, 4);
		random_actions(500);
		drain();
		// long stall on the receiver while the sender keeps offering
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			random_actions(20);
		join
		drain();
		send_idle = 63; recv_idle = 35;
		write_reg(REG_SLOTS, 64); write_reg(REG_PERIOD, 65535);
		write_reg(REG_LEVEL, 64);
		random_actions(500);
		drain();
		send_idle = 0; recv_idle = 0;
		write_reg(REG_SLOTS, 5); write_reg(REG_PERIOD, 1);
		write_reg(REG_SYNC, 0); write_reg(REG_LEVEL, 0);
		random_actions(300);
		drain();
		write_reg(REG_SLOTS, 3); write_reg(REG_PERIOD, 7);
		write_reg(REG_SYNC, 1); write_reg(REG_LEVEL, 1);
		random_actions(280);
		drain();
		if (errors == 0)
			$display("multi_reader_block_ring_control verification clean");
		else
			$display("multi_reader_block_ring_control verification failed");
		$finish;
	end
endmodule
